/* design/pad_pkg.sv */
// Package for polar_angle_degrees: shared constants, item flags, CORDIC angle table functions.
`default_nettype none
package pad_pkg;

  localparam int NORM_W     = 64;
  localparam int NORM_LIMIT = 60;
  localparam int GUARD_BITS = 8;

  localparam logic [63:0] DEC_SCALE   = 64'd10000000000000000;
  localparam logic [63:0] RAD_DEG_DEC = 64'd572957795130823209;

  typedef struct packed {
    logic dx_neg;
    logic dy_neg;
    logic dx_zero;
    logic dy_zero;
  } pad_info_t;

  // atan(2^-i) in degrees, scaled by 1e16
  function automatic logic [63:0] pad_atan_dec(input int i);
    logic [63:0] v;
    begin
      unique case (i)
        0:       v = 64'd450000000000000000;
        1:       v = 64'd265650511770779900;
        2:       v = 64'd140362434679264790;
        3:       v = 64'd71250163489017980;
        4:       v = 64'd35763343749973511;
        5:       v = 64'd17899106082460694;
        6:       v = 64'd8951737102110744;
        7:       v = 64'd4476141708605531;
        8:       v = 64'd2238105003685381;
        9:       v = 64'd1119056770662069;
        10:      v = 64'd559528918938037;
        11:      v = 64'd279764526170037;
        12:      v = 64'd139882271422650;
        13:      v = 64'd69941136753529;
        14:      v = 64'd34970568507040;
        15:      v = 64'd17485284269804;
        16:      v = 64'd8742642136938;
        default: v = RAD_DEG_DEC >> i;
      endcase
      return v;
    end
  endfunction

  // step angle in units of 2^-int_frac degrees, rounded
  function automatic logic [63:0] pad_step_angle(input int i, input int int_frac);
    logic [63:0] v;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] f;
    begin
      v = pad_atan_dec(i);
      q = v / DEC_SCALE;
      r = v % DEC_SCALE;
      f = '0;
      for (int b = 0; b < int_frac; b++) begin
        r = r << 1;
        f = f << 1;
        if (r >= DEC_SCALE) begin
          f = f | 64'd1;
          r = r - DEC_SCALE;
        end
      end
      if ((r << 1) >= DEC_SCALE) begin
        f = f + 64'd1;
      end
      return (q << int_frac) + f;
    end
  endfunction

endpackage
`default_nettype wire

/* design/polar_angle_degrees.sv */
// Top level of polar_angle_degrees: pipelined CORDIC direction angle in degrees.
//
// Usage:
//   Drive in_point_x/y and in_ref_x/y with start high; the item is taken at
//   any rising edge where start is high and busy is low. busy is high during
//   reset and until the first rising edge with rst_n high, then stays low, so
//   one item can enter every cycle.
//   Each result is on out_angle_deg / out_coincident for one cycle with
//   out_valid high, after the item has passed a difference stage, an absolute
//   value stage, three normalization stages, one stage per CORDIC iteration
//   (ANGLE_FRAC_BITS + 8 of them), a clamp/round stage and a quadrant stage.
//   Results come out in input order at the input rate; the receiver cannot
//   stall the block and no result is ever held back.
//   Reset clears every stage valid bit, so items in flight are dropped.
//   Coincident points give out_coincident = 1 and angle 0.
`default_nettype none
module polar_angle_degrees
  import pad_pkg::*;
#(
  parameter int COORD_WIDTH     = 32,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire  [COORD_WIDTH-1:0]           in_point_x,
  input  wire  [COORD_WIDTH-1:0]           in_point_y,
  input  wire  [COORD_WIDTH-1:0]           in_ref_x,
  input  wire  [COORD_WIDTH-1:0]           in_ref_y,
  output logic                             out_valid,
  output logic [ANGLE_FRAC_BITS+8:0]       out_angle_deg,
  output logic                             out_coincident
);

  localparam int DW       = COORD_WIDTH + 1;
  localparam int AW       = ANGLE_FRAC_BITS + 9;
  localparam int INT_FRAC = ANGLE_FRAC_BITS + GUARD_BITS;
  localparam int ITER     = ANGLE_FRAC_BITS + 8;
  localparam int ZW       = INT_FRAC + 10;
  localparam int LATENCY  = ITER + 7;

  localparam logic [AW-1:0] DEG_90  = {9'd90,  {ANGLE_FRAC_BITS{1'b0}}};
  localparam logic [AW-1:0] DEG_180 = {9'd180, {ANGLE_FRAC_BITS{1'b0}}};
  localparam logic [AW-1:0] DEG_270 = {9'd270, {ANGLE_FRAC_BITS{1'b0}}};
  localparam logic [AW-1:0] DEG_360 = {9'd360, {ANGLE_FRAC_BITS{1'b0}}};
  localparam logic [ZW-1:0] Z_TOP   = {1'b0, 9'd90, {INT_FRAC{1'b0}}};
  localparam logic [ZW-1:0] Z_HALF  = ZW'(1) << (GUARD_BITS - 1);

  logic accept;
  logic busy_r;

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // ---------------- difference stage
  logic [DW-1:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic          dv_r;

  assign dx_nxt = {in_point_x[COORD_WIDTH-1], in_point_x} - {in_ref_x[COORD_WIDTH-1], in_ref_x};
  assign dy_nxt = {in_point_y[COORD_WIDTH-1], in_point_y} - {in_ref_y[COORD_WIDTH-1], in_ref_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= 1'b0;
    end else begin
      dv_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
  end

  // ---------------- absolute value stage (index 0), normalization 1..3
  logic [NORM_W-1:0] nx_r [0:3];
  logic [NORM_W-1:0] ny_r [0:3];
  logic [NORM_W-1:0] nm_r [0:3];
  logic              nv_r [0:3];
  pad_info_t         ninfo_r [0:3];

  logic [DW-1:0]     ax_nxt, ay_nxt;
  pad_info_t         info_nxt;

  always_comb begin
    info_nxt.dx_neg  = dx_r[DW-1];
    info_nxt.dy_neg  = dy_r[DW-1];
    info_nxt.dx_zero = (dx_r == '0);
    info_nxt.dy_zero = (dy_r == '0);
    ax_nxt = dx_r[DW-1] ? (~dx_r + DW'(1)) : dx_r;
    ay_nxt = dy_r[DW-1] ? (~dy_r + DW'(1)) : dy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r[0] <= 1'b0;
    end else begin
      nv_r[0] <= dv_r;
    end
  end

  always_ff @(posedge clk) begin
    nx_r[0]    <= {{(NORM_W-DW){1'b0}}, ax_nxt};
    ny_r[0]    <= {{(NORM_W-DW){1'b0}}, ay_nxt};
    nm_r[0]    <= {{(NORM_W-DW){1'b0}}, (ax_nxt > ay_nxt) ? ax_nxt : ay_nxt};
    ninfo_r[0] <= info_nxt;
  end

  // two greedy left shifts per stage: 32,16 / 8,4 / 2,1
  for (genvar k = 1; k <= 3; k++) begin : g_norm
    localparam int SA = 128 >> (2 * k);
    localparam int SB = SA / 2;

    logic [NORM_W-1:0] x1, y1, m1, x2, y2, m2;

    always_comb begin
      x1 = nx_r[k-1];
      y1 = ny_r[k-1];
      m1 = nm_r[k-1];
      if ((nm_r[k-1] >> (NORM_LIMIT - SA)) == '0) begin
        x1 = nx_r[k-1] << SA;
        y1 = ny_r[k-1] << SA;
        m1 = nm_r[k-1] << SA;
      end
      x2 = x1;
      y2 = y1;
      m2 = m1;
      if ((m1 >> (NORM_LIMIT - SB)) == '0) begin
        x2 = x1 << SB;
        y2 = y1 << SB;
        m2 = m1 << SB;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nv_r[k] <= 1'b0;
      end else begin
        nv_r[k] <= nv_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      nx_r[k]    <= x2;
      ny_r[k]    <= y2;
      nm_r[k]    <= m2;
      ninfo_r[k] <= ninfo_r[k-1];
    end
  end

  // ---------------- CORDIC vectoring, one iteration per stage
  logic signed [NORM_W-1:0] cx_r [0:ITER-1];
  logic signed [NORM_W-1:0] cy_r [0:ITER-1];
  logic signed [ZW-1:0]     cz_r [0:ITER-1];
  logic                     cv_r [0:ITER-1];
  pad_info_t                cinfo_r [0:ITER-1];

  for (genvar i = 0; i < ITER; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] ANG = ZW'(pad_step_angle(i, INT_FRAC));

    logic signed [NORM_W-1:0] x_in, y_in, x_nxt, y_nxt;
    logic signed [ZW-1:0]     z_in, z_nxt;
    logic                     v_in;
    pad_info_t                info_in;

    if (i == 0) begin : g_first
      assign x_in    = signed'(nx_r[3]);
      assign y_in    = signed'(ny_r[3]);
      assign z_in    = '0;
      assign v_in    = nv_r[3];
      assign info_in = ninfo_r[3];
    end else begin : g_next
      assign x_in    = cx_r[i-1];
      assign y_in    = cy_r[i-1];
      assign z_in    = cz_r[i-1];
      assign v_in    = cv_r[i-1];
      assign info_in = cinfo_r[i-1];
    end

    always_comb begin
      if (!y_in[NORM_W-1]) begin
        x_nxt = x_in + (y_in >>> i);
        y_nxt = y_in - (x_in >>> i);
        z_nxt = z_in + ANG;
      end else begin
        x_nxt = x_in - (y_in >>> i);
        y_nxt = y_in + (x_in >>> i);
        z_nxt = z_in - ANG;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i] <= 1'b0;
      end else begin
        cv_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      cx_r[i]    <= x_nxt;
      cy_r[i]    <= y_nxt;
      cz_r[i]    <= z_nxt;
      cinfo_r[i] <= info_in;
    end
  end

  // ---------------- clamp and round
  logic [AW-1:0] phi_r, phi_nxt;
  logic          pv_r;
  pad_info_t     pinfo_r;
  logic [ZW-1:0] zc, zr;

  always_comb begin
    priority if (cz_r[ITER-1][ZW-1]) begin
      zc = '0;
    end else if (unsigned'(cz_r[ITER-1]) > Z_TOP) begin
      zc = Z_TOP;
    end else begin
      zc = unsigned'(cz_r[ITER-1]);
    end
    zr      = zc + Z_HALF;
    phi_nxt = zr[AW+GUARD_BITS-1:GUARD_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= cv_r[ITER-1];
    end
  end

  always_ff @(posedge clk) begin
    phi_r   <= phi_nxt;
    pinfo_r <= cinfo_r[ITER-1];
  end

  // ---------------- quadrant placement
  logic [AW:0]   ang_ext;
  logic [AW-1:0] ang_nxt;
  logic          coinc_nxt;
  logic          ov_r;
  logic [AW-1:0] ang_r;
  logic          coinc_r;

  always_comb begin
    coinc_nxt = 1'b0;
    priority if (pinfo_r.dx_zero && pinfo_r.dy_zero) begin
      coinc_nxt = 1'b1;
      ang_ext   = '0;
    end else if (pinfo_r.dx_zero) begin
      ang_ext = {1'b0, pinfo_r.dy_neg ? DEG_270 : DEG_90};
    end else if (pinfo_r.dy_zero) begin
      ang_ext = {1'b0, pinfo_r.dx_neg ? DEG_180 : {AW{1'b0}}};
    end else if (!pinfo_r.dx_neg) begin
      ang_ext = pinfo_r.dy_neg ? ({1'b0, DEG_360} - {1'b0, phi_r}) : {1'b0, phi_r};
    end else begin
      ang_ext = pinfo_r.dy_neg ? ({1'b0, DEG_180} + {1'b0, phi_r})
                               : ({1'b0, DEG_180} - {1'b0, phi_r});
    end
    if (ang_ext >= {1'b0, DEG_360}) begin
      ang_ext = ang_ext - {1'b0, DEG_360};
    end
    ang_nxt = ang_ext[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    ang_r   <= ang_nxt;
    coinc_r <= coinc_nxt;
  end

  assign out_valid      = ov_r;
  assign out_angle_deg  = ang_r;
  assign out_coincident = coinc_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without an item accepted at the pipeline depth");

  a_coinc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_coincident) |-> (out_angle_deg == '0))
    else $error("coincident item with nonzero angle");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle_deg < DEG_360))
    else $error("angle at or above 360 degrees");
`endif

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for polar_angle_degrees: predicts each CORDIC angle and compares.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CW          = 32;
  localparam int          AFB         = 16;
  localparam int          FRAC        = AFB + 8;
  localparam int          ITER        = AFB + 8;
  localparam int          AW          = AFB + 9;
  localparam int          GAP_MAX     = 40;
  localparam int          DRAIN_CYC   = 64;
  localparam int          STALL_LIMIT = 2000;
  localparam int          MAX_REPORTS = 10;
  localparam logic [CW-1:0] CMAX      = 32'h7FFF_FFFF;
  localparam logic [CW-1:0] CMIN      = 32'h8000_0000;
  localparam longint      ONE_DEG     = 64'sd1 <<< AFB;
  localparam longint      FULL_TURN   = 360 * ONE_DEG;
  localparam longint      NORM_TOP    = 64'sd1 <<< 59;
  localparam longint unsigned E16     = 64'd10000000000000000;
  localparam longint unsigned DEG_PER_RAD_E16 = 64'd572957795130823209;
  localparam logic [63:0] ATAN_DEG_E16 [0:16] = '{
    64'd450000000000000000, 64'd265650511770779900, 64'd140362434679264790,
    64'd71250163489017980, 64'd35763343749973511, 64'd17899106082460694,
    64'd8951737102110744, 64'd4476141708605531, 64'd2238105003685381,
    64'd1119056770662069, 64'd559528918938037, 64'd279764526170037,
    64'd139882271422650, 64'd69941136753529, 64'd34970568507040,
    64'd17485284269804, 64'd8742642136938
  };

  typedef struct packed {
    logic [AW-1:0] angle;
    logic          coin;
  } angle_result_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic [CW-1:0] in_point_x = '0;
  logic [CW-1:0] in_point_y = '0;
  logic [CW-1:0] in_ref_x = '0;
  logic [CW-1:0] in_ref_y = '0;
  wire           busy;
  wire           out_valid;
  wire  [AW-1:0] out_angle_deg;
  wire           out_coincident;

  longint        rot_step [0:ITER-1];
  angle_result_t pending_angles [$];
  angle_result_t got_want;
  int            fail_count = 0;
  int            sender_idle_pct = 0;
  int            quiet_cycles = 0;

  polar_angle_degrees i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_ref_x      (in_ref_x),
    .in_ref_y      (in_ref_y),
    .out_valid     (out_valid),
    .out_angle_deg (out_angle_deg),
    .out_coincident(out_coincident)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // degrees scaled by 1e16 -> units of 2^-FRAC degrees, round half up
  function automatic longint e16_to_units(input longint unsigned v);
    longint unsigned whole, rem, frac;
    whole = v / E16;
    rem   = v % E16;
    frac  = 0;
    for (int b = 0; b < FRAC; b++) begin
      rem  = rem << 1;
      frac = frac << 1;
      if (rem >= E16) begin
        frac = frac | 64'd1;
        rem  = rem - E16;
      end
    end
    if ((rem << 1) >= E16) begin
      frac = frac + 64'd1;
    end
    return longint'((whole << FRAC) + frac);
  endfunction

  function automatic longint first_quadrant_angle(input longint ax, input longint ay);
    longint x, y, z, xs, ys, mag;
    x   = ax;
    y   = ay;
    z   = 0;
    mag = (ax > ay) ? ax : ay;
    while (mag < NORM_TOP) begin
      mag = mag <<< 1;
      x   = x <<< 1;
      y   = y <<< 1;
    end
    for (int i = 0; i < ITER; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + rot_step[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - rot_step[i];
      end
    end
    if (z < 0) z = 0;
    if (z > (longint'(90) <<< FRAC)) z = longint'(90) <<< FRAC;
    return (z + (64'sd1 <<< (FRAC - AFB - 1))) >>> (FRAC - AFB);
  endfunction

  function automatic angle_result_t predict_angle(input logic [CW-1:0] px, input logic [CW-1:0] py,
                                                  input logic [CW-1:0] rx, input logic [CW-1:0] ry);
    longint        dx, dy, phi, ang;
    angle_result_t res;
    dx = longint'($signed(px)) - longint'($signed(rx));
    dy = longint'($signed(py)) - longint'($signed(ry));
    res.coin = 1'b0;
    if (dx == 0 && dy == 0) begin
      res.angle = '0;
      res.coin  = 1'b1;
      return res;
    end
    if (dx == 0) begin
      ang = (dy > 0) ? 90 * ONE_DEG : 270 * ONE_DEG;
    end else if (dy == 0) begin
      ang = (dx > 0) ? 0 : 180 * ONE_DEG;
    end else begin
      phi = first_quadrant_angle((dx < 0) ? -dx : dx, (dy < 0) ? -dy : dy);
      if (dx > 0) ang = (dy > 0) ? phi : FULL_TURN - phi;
      else        ang = (dy > 0) ? 180 * ONE_DEG - phi : 180 * ONE_DEG + phi;
    end
    if (ang >= FULL_TURN) ang = ang - FULL_TURN;
    res.angle = ang[AW-1:0];
    return res;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic hold_off();
    int n;
    n = 0;
    while (n < GAP_MAX && $urandom_range(0, 99) < sender_idle_pct) n++;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_point(input logic [CW-1:0] px, input logic [CW-1:0] py,
                            input logic [CW-1:0] rx, input logic [CW-1:0] ry);
    start      <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    in_ref_x   <= rx;
    in_ref_y   <= ry;
    do @(posedge clk); while (busy);
    pending_angles.push_back(predict_angle(px, py, rx, ry));
    hold_off();
  endtask

  task automatic test_coincident();
    send_point('0, '0, '0, '0);
    send_point(CMAX, CMIN, CMAX, CMIN);
    send_point('1, '1, '1, '1);
  endtask

  task automatic test_axes();
    send_point(32'd5, CMAX, 32'd5, CMIN);
    send_point(CMIN, CMIN, CMIN, CMAX);
    send_point('0, 32'd1, '0, '0);
    send_point('1, '1, '1, '0);
    send_point(CMAX, 32'd7, CMIN, 32'd7);
    send_point(CMIN, '0, CMAX, '0);
    send_point(32'd1, CMAX, '0, CMAX);
  endtask

  task automatic test_quadrants();
    send_point(32'd100, 32'd100, '0, '0);
    send_point(32'hFFFF_FF9C, 32'd100, '0, '0);
    send_point(32'hFFFF_FF9C, 32'hFFFF_FF9C, '0, '0);
    send_point(32'd100, 32'hFFFF_FF9C, '0, '0);
    send_point(CMAX, CMAX, CMIN, CMIN);
    send_point(CMIN, CMIN, CMAX, CMAX);
    send_point(CMAX, CMIN, CMIN, CMAX);
    send_point(CMIN, CMAX, CMAX, CMIN);
    // 360 - phi rounds up to a full turn and wraps to zero
    send_point(CMAX, '1, CMIN, '0);
    send_point(32'd1, CMIN, '0, CMAX);
    send_point(32'h0001_0000, 32'h0001_BB68, '0, '0);
    send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555);
  endtask

  task automatic test_random(input int idle_pct, input int count);
    logic [CW-1:0] px, py, rx, ry;
    sender_idle_pct = idle_pct;
    for (int k = 0; k < count; k++) begin
      px = $urandom;
      py = $urandom;
      rx = $urandom;
      ry = $urandom;
      case ($urandom_range(0, 9))
        4, 5: begin
          rx = px + 32'($urandom_range(0, 511)) - 32'd256;
          ry = py + 32'($urandom_range(0, 511)) - 32'd256;
        end
        6: rx = px;
        7: ry = py;
        8: begin
          rx = px;
          ry = py;
        end
        9: begin
          px = 32'($urandom_range(0, 31)) - 32'd16;
          py = 32'($urandom_range(0, 31)) - 32'd16;
          rx = 32'($urandom_range(0, 31)) - 32'd16;
          ry = 32'($urandom_range(0, 31)) - 32'd16;
        end
        default: ;
      endcase
      send_point(px, py, rx, ry);
    end
    sender_idle_pct = 0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_angles.size() == 0) begin
        note_failure($sformatf("result with nothing pending: angle=%0d coincident=%0b",
                               out_angle_deg, out_coincident));
      end else begin
        got_want = pending_angles.pop_front();
        if (out_angle_deg !== got_want.angle || out_coincident !== got_want.coin) begin
          note_failure($sformatf("mismatch: angle exp=%0d got=%0d, coincident exp=%0b got=%0b",
                                 got_want.angle, out_angle_deg, got_want.coin, out_coincident));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < ITER; i++) begin
      if (i <= 16) rot_step[i] = e16_to_units(ATAN_DEG_E16[i]);
      else         rot_step[i] = e16_to_units(DEG_PER_RAD_E16 >> i);
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_coincident();
    test_axes();
    test_quadrants();
    test_random(0, 450);
    test_random(70, 450);
    test_random(25, 450);
    test_random(0, 450);
    start <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (pending_angles.size() != 0) note_failure("results still pending at end of run");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* polar_angle_degrees.f */
design/pad_pkg.sv
design/polar_angle_degrees.sv
dv/tb_top.sv
